>>> sv/pmc_pkg.sv
// Package with shared types and constants of the path maximum curvature unit.
`default_nettype none
package pmc_pkg;
  localparam int CoordW = 24;
  localparam int CurvW  = 24;
  localparam logic [CurvW-1:0] CurvMax = 24'hFFFFFF;

  // One classified point task handed from the front end to the back end.
  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
    logic                     do_curv;
    logic                     last;
  } task_t;
endpackage
`default_nettype wire

>>> sv/pmc_front.sv
// Front end: accepts points, keeps the point history and issues tasks.
`default_nettype none
module pmc_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [pmc_pkg::CoordW-1:0] in_x,
  input  wire [pmc_pkg::CoordW-1:0] in_y,
  input  wire                       in_last,
  output logic                      task_valid,
  input  wire                       task_ready,
  output pmc_pkg::task_t            task_data
);
  logic [pmc_pkg::CoordW-1:0] ox_r, oy_r, nx_r, ny_r;
  logic [1:0] seen_r;

  assign in_ready   = task_ready;
  assign task_valid = in_valid;
  always_comb begin
    task_data.x0 = ox_r;
    task_data.y0 = oy_r;
    task_data.x1 = nx_r;
    task_data.y1 = ny_r;
    task_data.x2 = in_x;
    task_data.y2 = in_y;
    task_data.do_curv = (seen_r == 2'd2);
    task_data.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      ox_r <= '0; oy_r <= '0; nx_r <= '0; ny_r <= '0;
    end else if (in_valid && in_ready) begin
      if (in_last) begin
        seen_r <= 2'd0;
        ox_r <= '0; oy_r <= '0; nx_r <= '0; ny_r <= '0;
      end else begin
        ox_r <= nx_r; oy_r <= ny_r; nx_r <= in_x; ny_r <= in_y;
        if (seen_r != 2'd2) seen_r <= seen_r + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/pmc_fifo.sv
// Two-entry task queue between the front end and the back end.
`default_nettype none
module pmc_fifo (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             wr_valid,
  output logic            wr_ready,
  input  pmc_pkg::task_t  wr_data,
  output logic            rd_valid,
  input  wire             rd_ready,
  output pmc_pkg::task_t  rd_data
);
  pmc_pkg::task_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 2'd1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule
`default_nettype wire

>>> sv/pmc_back.sv
// Back end: curvature of one point triple, running maximum and the result register.
`default_nettype none
module pmc_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      task_valid,
  output logic                     task_ready,
  input  pmc_pkg::task_t           task_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [pmc_pkg::CurvW-1:0] out_curv
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_SQRT, S_DMUL1, S_DMUL2, S_DMUL3, S_DIV, S_DONE
  } state_t;

  state_t state_r;
  logic last_r, do_r;
  logic signed [24:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [49:0] sq_r [6];
  logic [25:0] root_r [3];
  logic [4:0]  sqi_r;         // 26 root bits
  logic [25:0] la_r, lb_r, lc_r;
  logic signed [49:0] p1_r, p2_r;
  logic [51:0] ab_r;
  logic [77:0] den_r;
  logic [98:0] num_r;          // 2*|cross| << 32 minus subtracted terms
  logic [4:0]  qi_r;
  logic [23:0] q_r, max_r;
  logic sat_r;

  assign task_ready = (state_r == S_IDLE) && !out_valid;

  // Square root remainder and the radicand pairs are kept as separate registers.
  logic [51:0] srem_r [3];
  logic [51:0] srad_r [3];
  logic [51:0] st [3];
  logic [51:0] sr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sr[i] = {srem_r[i][49:0], srad_r[i][51:50]};
      st[i] = {24'd0, root_r[i], 2'b01};
    end
  end

  // Division compare of the remaining numerator against the shifted denominator.
  logic [98:0] dshift;
  assign dshift = {21'd0, den_r} << qi_r;

  logic [49:0] cr_abs;
  logic signed [50:0] cr;
  assign cr = 51'(p1_r) - 51'(p2_r);
  assign cr_abs = cr[50] ? 50'(-cr) : cr[49:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      max_r <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (task_valid && task_ready) begin
            last_r <= task_data.last;
            do_r   <= task_data.do_curv;
            ax_r <= 25'(task_data.x1) - 25'(task_data.x0);
            ay_r <= 25'(task_data.y1) - 25'(task_data.y0);
            bx_r <= 25'(task_data.x2) - 25'(task_data.x1);
            by_r <= 25'(task_data.y2) - 25'(task_data.y1);
            cx_r <= 25'(task_data.x2) - 25'(task_data.x0);
            cy_r <= 25'(task_data.y2) - 25'(task_data.y0);
            state_r <= task_data.do_curv ? S_MUL : S_DONE;
          end
        end
        S_MUL: begin
          sq_r[0] <= 50'(ax_r * ax_r); sq_r[1] <= 50'(ay_r * ay_r);
          sq_r[2] <= 50'(bx_r * bx_r); sq_r[3] <= 50'(by_r * by_r);
          sq_r[4] <= 50'(cx_r * cx_r); sq_r[5] <= 50'(cy_r * cy_r);
          p1_r <= 50'(ax_r * by_r);
          p2_r <= 50'(ay_r * bx_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          for (int i = 0; i < 3; i++) begin
            srad_r[i] <= 52'(sq_r[2*i]) + 52'(sq_r[2*i+1]);
            srem_r[i] <= '0;
            root_r[i] <= '0;
          end
          num_r <= {48'd0, cr_abs, 1'b0} << 32;
          sqi_r <= 5'd0;
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          for (int i = 0; i < 3; i++) begin
            srad_r[i] <= {srad_r[i][49:0], 2'b00};
            if (sr[i] >= st[i]) begin
              srem_r[i] <= sr[i] - st[i];
              root_r[i] <= {root_r[i][24:0], 1'b1};
            end else begin
              srem_r[i] <= sr[i];
              root_r[i] <= {root_r[i][24:0], 1'b0};
            end
          end
          sqi_r <= sqi_r + 5'd1;
          if (sqi_r == 5'd25) state_r <= S_DMUL1;
        end
        S_DMUL1: begin
          la_r <= root_r[0]; lb_r <= root_r[1]; lc_r <= root_r[2];
          state_r <= S_DMUL2;
        end
        S_DMUL2: begin
          ab_r <= 52'(la_r * lb_r);
          if (la_r == '0 || lb_r == '0 || lc_r == '0) state_r <= S_DONE;
          else state_r <= S_DMUL3;
        end
        S_DMUL3: begin
          // 52 x 26 product split into two partial products of at most 26 x 26.
          den_r <= 78'(ab_r[25:0] * lc_r) + (78'(ab_r[51:26] * lc_r) << 26);
          qi_r <= 5'd24;
          q_r <= '0;
          sat_r <= 1'b0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (num_r >= dshift) begin
            if (qi_r == 5'd24) sat_r <= 1'b1;
            else begin
              num_r <= num_r - dshift;
              q_r[qi_r[4:0]] <= 1'b1;
            end
          end
          if (qi_r == 5'd0 || (qi_r == 5'd24 && num_r >= dshift)) state_r <= S_DONE;
          else qi_r <= qi_r - 5'd1;
        end
        S_DONE: begin
          logic [23:0] k;
          k = sat_r ? pmc_pkg::CurvMax : q_r;
          if (do_r && la_r != '0 && lb_r != '0 && lc_r != '0 && k > max_r) max_r <= k;
          if (last_r) begin
            out_curv  <= (do_r && la_r != '0 && lb_r != '0 && lc_r != '0 && k > max_r) ?
                         k : max_r;
            out_valid <= 1'b1;
            max_r <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/path_max_curvature_unit.sv
// Top level of the path maximum curvature unit.
//
// Channel  Dir  Payload
// in_      in   tdata = x_coord[23:0], y_coord[47:24]; tlast = last_point
// out_     out  tdata = max_curvature[23:0]
//
// A point with two earlier points holds the back end for the accepting step,
// one product step, one sum step, 26 square root steps (three lanes side by
// side), three denominator steps, up to 25 division steps and one update step;
// the serial square root and divider make up most of this work. A saturating
// quotient ends the division after its first step, and coincident points end it
// before it starts. Other points take only the accepting and the update step.
// Reset is synchronous and active low and clears the history, the queue and the
// maximum. The front end stalls only on a full queue; the back end stalls while
// a result waits to be taken.
`default_nettype none
module path_max_curvature_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // x_coord[23:0], y_coord[47:24]
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata   // max_curvature[23:0]
);
  logic tv, tr, qv, qr;
  pmc_pkg::task_t td, qd;

  pmc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_x(in_tdata[23:0]), .in_y(in_tdata[47:24]), .in_last(in_tlast),
    .task_valid(tv), .task_ready(tr), .task_data(td)
  );
  pmc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(tv), .wr_ready(tr), .wr_data(td),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qd)
  );
  pmc_back u_back (
    .clk(clk), .rst_n(rst_n), .task_valid(qv), .task_ready(qr), .task_data(qd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_curv(out_tdata)
  );
endmodule
`default_nettype wire

>>> sv/pmc_checker.sv
// Port-level checker of the path maximum curvature unit and its bind.
`default_nettype none
module pmc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        in_tlast,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);
  // Paths whose last point went in and whose result has not yet been taken.
  logic [3:0] pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 4'(in_tvalid && in_tready && in_tlast)
                       - 4'(out_tvalid && out_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 4'd0)
    else $error("unexpected result");
endmodule
bind path_max_curvature_unit pmc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire
